@@ rtl/hrp_pkg.sv @@
// Shared types and codes for the heap resize policy block.
`default_nettype none
package hrp_pkg;

  // Wait states as reported on the result channel
  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_MOVE   = 2'd1;
  localparam logic [1:0] ST_GROW   = 2'd2;
  localparam logic [1:0] ST_SHRINK = 2'd3;

  // Actions
  localparam logic [2:0] AC_NONE     = 3'd0;
  localparam logic [2:0] AC_MOVE     = 3'd1;
  localparam logic [2:0] AC_GROW     = 3'd2;
  localparam logic [2:0] AC_SHRINK   = 3'd3;
  localparam logic [2:0] AC_WAITGROW = 3'd4;
  localparam logic [2:0] AC_SLACK    = 3'd5;

  // Rule set codes
  localparam logic [3:0] VAR_SIMPLE      = 4'd0;
  localparam logic [3:0] VAR_WAIT        = 4'd1;
  localparam logic [3:0] VAR_AGGR_GROW   = 4'd2;
  localparam logic [3:0] VAR_AGGR_SHRINK = 4'd3;
  localparam logic [3:0] VAR_GROW_AFTER  = 4'd4;
  localparam logic [3:0] VAR_OPT_SHRINK  = 4'd5;
  localparam logic [3:0] VAR_SHRINK_AFTER = 4'd6;
  localparam logic [3:0] VAR_OPT_GROW    = 4'd7;
  localparam logic [3:0] VAR_FULL        = 4'd8;

  // Register indexes
  localparam logic [1:0] REG_VARIANT = 2'd0;
  localparam logic [1:0] REG_DRAM    = 2'd1;
  localparam logic [1:0] REG_EPSILON = 2'd2;

  // 100 ms in Q32.8
  localparam logic [39:0] EPSILON_RESET = 40'd25600;

  // Item kinds
  localparam logic OP_DECIDE = 1'b0;
  localparam logic OP_EPILOG = 1'b1;

  typedef struct packed {
    logic        op;
    logic [39:0] gc_time;
    logic [39:0] io_time;
    logic        device_busy;
    logic [47:0] candidate_bytes;
    logic [47:0] heap_capacity_bytes;
    logic [47:0] old_capacity_bytes;
    logic [47:0] old_used_bytes;
    logic [47:0] old_max_bytes;
    logic [47:0] resident_bytes;
    logic [47:0] cache_bytes;
    logic [1:0]  epilog_flags;
  } in_item_t;

  typedef struct packed {
    logic bal;
    logic gc_ge;
    logic gc_gt;
    logic io_gt;
    logic cand;
    logic under;
    logic high;
    logic slack;
    logic busy;
  } preds_t;

  // Item as seen by the decision stage
  typedef struct packed {
    logic       op;
    logic [1:0] epilog_flags;
    preds_t     p;
  } dec_item_t;

  typedef struct packed {
    logic       epilog_cleared;
    logic       eager_written;
    logic       move_eager;
    logic [2:0] action;
    logic [1:0] next_state;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/hrp_pred.sv @@
// Input register and two-stage predicate evaluation (cross-multiplied ratios).
`default_nettype none
module hrp_pred (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire hrp_pkg::in_item_t in_item,
  input  wire logic [47:0]       dram_limit_bytes,
  input  wire logic [39:0]       time_epsilon,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hrp_pkg::dec_item_t     out_item
);
  import hrp_pkg::*;

  typedef struct packed {
    logic        op;
    logic [1:0]  epilog_flags;
    logic        busy;
    logic        gc_ge;
    logic        gc_gt;
    logic        under;
    logic [39:0] diff;
    logic [50:0] cand5;
    logic [48:0] heap2;
    logic [51:0] used10;
    logic [50:0] ocap7;
    logic [48:0] mem;
    logic [51:0] dram9;
  } arith_t;

  logic     v0, v1, v2;
  logic     rdy0, rdy1, rdy2;
  in_item_t s0;
  arith_t   s1, s1_next;
  dec_item_t s2, s2_next;
  logic [52:0] mem10;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_ready = rdy0;

  // Stage 1: scaled operands, time difference
  always_comb begin
    s1_next.op           = s0.op;
    s1_next.epilog_flags = s0.epilog_flags;
    s1_next.busy         = s0.device_busy;
    s1_next.gc_ge        = s0.gc_time >= s0.io_time;
    s1_next.gc_gt        = s0.gc_time > s0.io_time;
    s1_next.under        = s0.old_capacity_bytes < s0.old_max_bytes;
    s1_next.diff         = s1_next.gc_ge ? (s0.gc_time - s0.io_time)
                                         : (s0.io_time - s0.gc_time);
    s1_next.cand5  = {1'b0, s0.candidate_bytes, 2'b00} + {3'b000, s0.candidate_bytes};
    s1_next.heap2  = {s0.heap_capacity_bytes, 1'b0};
    s1_next.used10 = {1'b0, s0.old_used_bytes, 3'b000} + {3'b000, s0.old_used_bytes, 1'b0};
    s1_next.ocap7  = {s0.old_capacity_bytes, 3'b000} - {3'b000, s0.old_capacity_bytes};
    s1_next.mem    = {1'b0, s0.resident_bytes} + {1'b0, s0.cache_bytes};
    s1_next.dram9  = {1'b0, dram_limit_bytes, 3'b000} + {4'b0000, dram_limit_bytes};
  end

  // Stage 2: compares
  always_comb begin
    mem10 = {1'b0, s1.mem, 3'b000} + {3'b000, s1.mem, 1'b0};
    s2_next.op           = s1.op;
    s2_next.epilog_flags = s1.epilog_flags;
    s2_next.p.bal   = s1.diff <= time_epsilon;
    s2_next.p.gc_ge = s1.gc_ge;
    s2_next.p.gc_gt = s1.gc_gt;
    s2_next.p.io_gt = !s1.gc_ge;
    s2_next.p.cand  = s1.cand5 >= {2'b00, s1.heap2};
    s2_next.p.under = s1.under;
    s2_next.p.high  = s1.used10 > {1'b0, s1.ocap7};
    s2_next.p.slack = mem10 < {1'b0, s1.dram9};
    s2_next.p.busy  = s1.busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy0) v0 <= in_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) s0 <= in_item;
    if (rdy1 && v0) s1 <= s1_next;
    if (rdy2 && v1) s2 <= s2_next;
  end

  assign out_valid = v2;
  assign out_item  = s2;

endmodule
`default_nettype wire

@@ rtl/hrp_rules.sv @@
// Decision stage: wait state and action registers, rule sets, result register.
`default_nettype none
module hrp_rules (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [3:0]         variant,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hrp_pkg::dec_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hrp_pkg::result_t        out_result
);
  import hrp_pkg::*;

  typedef struct packed {
    logic [1:0] st;
    logic [2:0] ac;
  } sa_t;

  logic [1:0] wait_state;
  logic [2:0] pending_action;
  result_t    res_next;
  logic [3:0] v;
  logic       hit;
  logic       fire;
  sa_t        sa;

  function automatic sa_t put(input logic [1:0] st, input logic [2:0] ac);
    sa_t r;
    r.st = st;
    r.ac = ac;
    return r;
  endfunction

  function automatic sa_t rule_none(input preds_t p);
    sa_t r;
    if (p.bal)                    r = put(ST_NONE, AC_NONE);
    else if (p.gc_ge && p.cand)   r = put(ST_MOVE, AC_MOVE);
    else if (p.gc_ge && p.under)  r = put(ST_GROW, AC_GROW);
    else if (p.io_gt && p.busy)   r = put(ST_SHRINK, AC_SHRINK);
    else                          r = put(ST_NONE, AC_NONE);
    return r;
  endfunction

  function automatic sa_t rule_grow(input preds_t p, input logic [3:0] vs);
    sa_t r;
    if (p.bal) begin
      r = put(ST_GROW, AC_WAITGROW);
    end else if (vs == VAR_AGGR_GROW) begin
      if (p.gc_gt && p.high && p.under)       r = put(ST_GROW, AC_GROW);
      else if (p.gc_gt && !p.high && p.under) r = put(ST_GROW, AC_WAITGROW);
      else                                    r = put(ST_NONE, AC_NONE);
    end else if (vs == VAR_SHRINK_AFTER) begin
      if (p.io_gt)                  r = put(ST_SHRINK, AC_SHRINK);
      else if (p.gc_gt && !p.high)  r = put(ST_GROW, AC_WAITGROW);
      else                          r = put(ST_NONE, AC_NONE);
    end else if (vs == VAR_OPT_GROW || vs == VAR_FULL) begin
      if (p.io_gt)                            r = put(ST_SHRINK, AC_SHRINK);
      else if (p.gc_ge && p.cand)             r = put(ST_MOVE, AC_MOVE);
      else if (p.gc_gt && p.high && p.under)  r = put(ST_GROW, AC_GROW);
      else if (p.gc_gt && !p.high && p.under) r = put(ST_GROW, AC_WAITGROW);
      else                                    r = put(ST_NONE, AC_NONE);
    end else begin
      if (p.gc_gt && !p.high) r = put(ST_GROW, AC_WAITGROW);
      else                    r = put(ST_NONE, AC_NONE);
    end
    return r;
  endfunction

  function automatic sa_t rule_shrink(input preds_t p, input logic [3:0] vs);
    sa_t  r;
    logic strict;
    strict = (vs == VAR_AGGR_SHRINK) || (vs == VAR_GROW_AFTER) ||
             (vs == VAR_OPT_SHRINK) || (vs == VAR_FULL);
    if (p.bal)                                     r = put(ST_SHRINK, AC_SLACK);
    else if (vs == VAR_FULL && p.gc_ge && p.cand)  r = put(ST_MOVE, AC_MOVE);
    else if ((vs == VAR_OPT_SHRINK || vs == VAR_FULL) && p.gc_gt)
                                                   r = put(ST_GROW, AC_GROW);
    else if (strict && p.io_gt && !p.slack)        r = put(ST_SHRINK, AC_SHRINK);
    else if (p.io_gt && p.slack)                   r = put(ST_SHRINK, AC_SLACK);
    else if (vs == VAR_GROW_AFTER && p.gc_gt)      r = put(ST_GROW, AC_GROW);
    else                                           r = put(ST_NONE, AC_NONE);
    return r;
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    // out-of-range codes run the wait rule set
    v   = (variant > VAR_FULL) ? VAR_WAIT : variant;
    hit = 1'b0;
    sa  = put(wait_state, pending_action);
    res_next = '0;
    if (in_item.op == OP_EPILOG) begin
      if (v == VAR_SIMPLE) hit = in_item.epilog_flags[1] && (pending_action == AC_MOVE);
      else                 hit = in_item.epilog_flags[0] && (wait_state == ST_MOVE);
      if (hit) sa = put(ST_NONE, AC_NONE);
      res_next.epilog_cleared = hit;
    end else if (v == VAR_SIMPLE) begin
      sa = rule_none(in_item.p);
      res_next.move_eager    = (sa.ac == AC_MOVE);
      res_next.eager_written = 1'b1;
      sa.st = ST_NONE;
    end else begin
      unique case (wait_state)
        ST_GROW:   sa = rule_grow(in_item.p, v);
        ST_SHRINK: sa = rule_shrink(in_item.p, v);
        ST_MOVE: begin
          sa = put(ST_MOVE, AC_MOVE);
          res_next.eager_written = 1'b1;
        end
        default:   sa = rule_none(in_item.p);
      endcase
    end
    res_next.next_state = sa.st;
    res_next.action     = sa.ac;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_state     <= ST_NONE;
      pending_action <= AC_NONE;
      out_valid      <= 1'b0;
    end else begin
      if (fire) begin
        wait_state     <= sa.st;
        pending_action <= sa.ac;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_result <= res_next;
  end

`ifndef ASSERT_OFF
  a_state_matches_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (wait_state == out_result.next_state &&
                   pending_action == out_result.action))
    else $error("state register diverged from last result");
  a_move_pairs: assert property (@(posedge clk) disable iff (rst)
    wait_state == ST_MOVE |-> pending_action == AC_MOVE)
    else $error("wait-move state without move action");
  a_eager_only_written: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.move_eager |-> out_result.eager_written)
    else $error("eager move set without being written");
  a_clear_vs_eager: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_result.epilog_cleared && out_result.eager_written))
    else $error("epilog clear and eager write in one result");
  a_clear_to_none: assert property (@(posedge clk) disable iff (rst)
    fire && res_next.epilog_cleared |=> wait_state == ST_NONE && pending_action == AC_NONE)
    else $error("epilog clear did not reach no-action");
`endif

endmodule
`default_nettype wire

@@ rtl/heap_resize_policy_fsm.sv @@
// Top level of the heap resize policy: configuration registers and stream ports.
//
//   channel  | signals                          | width
//   s_*      | tvalid tready tdata tuser        | tdata 424, tuser 1 (op)
//   m_*      | tvalid tready tdata              | tdata 8
//   cfg_*    | wen index data                   | index 2, data 48
//
// One item per cycle sustained while m_tready is high; each result passes the
// input register, two predicate stages and the result register.
// The decision stage updates the wait state and action as each result is
// registered, so items see the state left by the item before them.
// Stalls: each stage holds while its successor is full, so holes are filled
// and transactions continue while a result waits on m_tready.
// Reset (rst, synchronous) empties the pipeline, clears state and action and
// loads the register defaults.
`default_nettype none
module heap_resize_policy_fsm (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // gc_time[39:0], io_time[79:40], device_busy[80], candidate_bytes[128:81],
  // heap_capacity_bytes[176:129], old_capacity_bytes[224:177],
  // old_used_bytes[272:225], old_max_bytes[320:273], resident_bytes[368:321],
  // cache_bytes[416:369], epilog_flags[418:417], zero fill[423:419]
  input  wire logic [423:0] s_tdata,
  // op[0]
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // next_state[1:0], action[4:2], move_eager[5], eager_written[6],
  // epilog_cleared[7]
  output logic [7:0]        m_tdata,
  input  wire logic         cfg_wen,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [47:0]  cfg_data
);
  import hrp_pkg::*;

  logic [3:0]  variant;
  logic [47:0] dram_limit_bytes;
  logic [39:0] time_epsilon;
  in_item_t    item;
  dec_item_t   dec;
  logic        dec_valid, dec_ready;
  result_t     res;

  always_ff @(posedge clk) begin
    if (rst) begin
      variant          <= VAR_SIMPLE;
      dram_limit_bytes <= '0;
      time_epsilon     <= EPSILON_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_VARIANT: variant          <= cfg_data[3:0];
        REG_DRAM:    dram_limit_bytes <= cfg_data;
        REG_EPSILON: time_epsilon     <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    item.op                  = s_tuser;
    item.gc_time             = s_tdata[39:0];
    item.io_time             = s_tdata[79:40];
    item.device_busy         = s_tdata[80];
    item.candidate_bytes     = s_tdata[128:81];
    item.heap_capacity_bytes = s_tdata[176:129];
    item.old_capacity_bytes  = s_tdata[224:177];
    item.old_used_bytes      = s_tdata[272:225];
    item.old_max_bytes       = s_tdata[320:273];
    item.resident_bytes      = s_tdata[368:321];
    item.cache_bytes         = s_tdata[416:369];
    item.epilog_flags        = s_tdata[418:417];
  end

  hrp_pred u_pred (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .in_item          (item),
    .dram_limit_bytes (dram_limit_bytes),
    .time_epsilon     (time_epsilon),
    .out_valid        (dec_valid),
    .out_ready        (dec_ready),
    .out_item         (dec)
  );

  hrp_rules u_rules (
    .clk        (clk),
    .rst        (rst),
    .variant    (variant),
    .in_valid   (dec_valid),
    .in_ready   (dec_ready),
    .in_item    (dec),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (res)
  );

  assign m_tdata = res;

endmodule
`default_nettype wire

@@ tb/sv/heap_resize_policy_fsm_tb.sv @@
// Self-checking testbench for the heap resize policy block.
`default_nettype none
module heap_resize_policy_fsm_tb;
  import hrp_pkg::*;

  localparam logic [63:0] MASK40 = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;
  localparam int unsigned ITEMS_PER_PHASE = 105;
  localparam int unsigned PHASES_PER_REGIME = 6;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [423:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;
  logic         cfg_wen = 1'b0;
  logic [1:0]   cfg_index = REG_VARIANT;
  logic [47:0]  cfg_data = '0;

  // Shadow of the configuration and of the policy state
  logic [3:0]   rule_set = VAR_SIMPLE;
  logic [47:0]  dram_budget = '0;
  logic [39:0]  balance_window = EPSILON_RESET;
  logic [1:0]   tier_state = ST_NONE;
  logic [2:0]   tier_action = AC_NONE;

  result_t      expected_results[$];
  int unsigned  tx_idle_pct;
  int unsigned  rx_idle_pct;
  int unsigned  failures = 0;
  int unsigned  n_decide = 0;
  int unsigned  n_epilog = 0;
  int unsigned  n_cleared = 0;
  int unsigned  n_settings = 0;
  int unsigned  seen_state[4] = '{0, 0, 0, 0};

  heap_resize_policy_fsm DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- policy rules
  // Each rule returns {next wait state, action}.
  function automatic logic [4:0] idle_rule(preds_t p);
    if (p.bal) return {ST_NONE, AC_NONE};
    if (p.gc_ge && p.cand) return {ST_MOVE, AC_MOVE};
    if (p.gc_ge && p.under) return {ST_GROW, AC_GROW};
    if (p.io_gt && p.busy) return {ST_SHRINK, AC_SHRINK};
    return {ST_NONE, AC_NONE};
  endfunction

  function automatic logic [4:0] grow_rule(preds_t p, logic [3:0] v);
    if (p.bal) return {ST_GROW, AC_WAITGROW};
    case (v) inside
      VAR_AGGR_GROW: begin
        if (p.gc_gt && p.high && p.under) return {ST_GROW, AC_GROW};
        if (p.gc_gt && !p.high && p.under) return {ST_GROW, AC_WAITGROW};
      end
      VAR_SHRINK_AFTER: begin
        if (p.io_gt) return {ST_SHRINK, AC_SHRINK};
        if (p.gc_gt && !p.high) return {ST_GROW, AC_WAITGROW};
      end
      VAR_OPT_GROW, VAR_FULL: begin
        if (p.io_gt) return {ST_SHRINK, AC_SHRINK};
        if (p.gc_ge && p.cand) return {ST_MOVE, AC_MOVE};
        if (p.gc_gt && p.high && p.under) return {ST_GROW, AC_GROW};
        if (p.gc_gt && !p.high && p.under) return {ST_GROW, AC_WAITGROW};
      end
      default: begin
        if (p.gc_gt && !p.high) return {ST_GROW, AC_WAITGROW};
      end
    endcase
    return {ST_NONE, AC_NONE};
  endfunction

  function automatic logic [4:0] shrink_rule(preds_t p, logic [3:0] v);
    if (p.bal) return {ST_SHRINK, AC_SLACK};
    if (v == VAR_FULL && p.gc_ge && p.cand) return {ST_MOVE, AC_MOVE};
    if ((v == VAR_OPT_SHRINK || v == VAR_FULL) && p.gc_gt) return {ST_GROW, AC_GROW};
    if ((v == VAR_AGGR_SHRINK || v == VAR_GROW_AFTER || v == VAR_OPT_SHRINK ||
         v == VAR_FULL) && p.io_gt && !p.slack)
      return {ST_SHRINK, AC_SHRINK};
    if (p.io_gt && p.slack) return {ST_SHRINK, AC_SLACK};
    if (v == VAR_GROW_AFTER && p.gc_gt) return {ST_GROW, AC_GROW};
    return {ST_NONE, AC_NONE};
  endfunction

  // Advances the shadow state by one item and returns the result it causes.
  function automatic result_t advance_policy(in_item_t it);
    result_t     r;
    preds_t      p;
    logic [3:0]  v;
    logic [63:0] gc, io, diff, mem;
    r = '0;
    v = (rule_set > VAR_FULL) ? VAR_WAIT : rule_set;
    if (it.op == OP_EPILOG) begin
      if (v == VAR_SIMPLE ? (it.epilog_flags[1] && tier_action == AC_MOVE)
                          : (it.epilog_flags[0] && tier_state == ST_MOVE)) begin
        tier_state = ST_NONE;
        tier_action = AC_NONE;
        r.epilog_cleared = 1'b1;
      end
    end else begin
      gc = 64'(it.gc_time);
      io = 64'(it.io_time);
      diff = (gc >= io) ? gc - io : io - gc;
      mem = 64'(it.resident_bytes) + 64'(it.cache_bytes);
      p.bal = diff <= 64'(balance_window);
      p.gc_ge = gc >= io;
      p.gc_gt = gc > io;
      p.io_gt = io > gc;
      p.cand = 64'd5 * 64'(it.candidate_bytes) >= 64'd2 * 64'(it.heap_capacity_bytes);
      p.under = it.old_capacity_bytes < it.old_max_bytes;
      p.high = 64'd10 * 64'(it.old_used_bytes) > 64'd7 * 64'(it.old_capacity_bytes);
      p.slack = 64'd10 * mem < 64'd9 * 64'(dram_budget);
      p.busy = it.device_busy;
      if (v == VAR_SIMPLE) begin
        {tier_state, tier_action} = idle_rule(p);
        r.move_eager = (tier_action == AC_MOVE);
        r.eager_written = 1'b1;
        tier_state = ST_NONE;
      end else begin
        case (tier_state)
          ST_GROW:   {tier_state, tier_action} = grow_rule(p, v);
          ST_SHRINK: {tier_state, tier_action} = shrink_rule(p, v);
          ST_MOVE: begin
            // pending move is held; eager flag written low
            tier_action = AC_MOVE;
            r.eager_written = 1'b1;
          end
          default:   {tier_state, tier_action} = idle_rule(p);
        endcase
      end
    end
    r.next_state = tier_state;
    r.action = tier_action;
    return r;
  endfunction

  // ---------------------------------------------------------------- item makers
  // Mix of zero, all ones, full-width and short random values.
  function automatic logic [63:0] rnd_field(int unsigned w);
    logic [63:0] x;
    int unsigned n;
    x = {$urandom, $urandom};
    n = $urandom_range(w, 1);
    case ($urandom_range(7)) inside
      0:       return 64'd0;
      1:       return (64'd1 << w) - 64'd1;
      2, 3:    return x & ((64'd1 << w) - 64'd1);
      default: return x & ((64'd1 << n) - 64'd1);
    endcase
  endfunction

  function automatic in_item_t decide_of(input logic [63:0] gc, io, input logic busy,
                                         input logic [63:0] cand, heap, ocap, oused, omax,
                                         res, cache);
    in_item_t it;
    it.op = OP_DECIDE;
    it.gc_time = gc[39:0];
    it.io_time = io[39:0];
    it.device_busy = busy;
    it.candidate_bytes = cand[47:0];
    it.heap_capacity_bytes = heap[47:0];
    it.old_capacity_bytes = ocap[47:0];
    it.old_used_bytes = oused[47:0];
    it.old_max_bytes = omax[47:0];
    it.resident_bytes = res[47:0];
    it.cache_bytes = cache[47:0];
    it.epilog_flags = 2'($urandom);
    return it;
  endfunction

  function automatic in_item_t epilog_of(logic [1:0] flags);
    in_item_t it;
    it = decide_of(rnd_field(40), rnd_field(40), 1'($urandom), rnd_field(48), rnd_field(48),
                   rnd_field(48), rnd_field(48), rnd_field(48), rnd_field(48), rnd_field(48));
    it.op = OP_EPILOG;
    it.epilog_flags = flags;
    return it;
  endfunction

  // Decide item whose comparisons sit on or near their thresholds most of the time.
  function automatic in_item_t rand_decide();
    logic [63:0] io, gc, gap, heap, cand, ocap, oused, omax, bound, mem, res, cache;
    io = rnd_field(40);
    case ($urandom_range(3))
      0:       gap = 64'd0;
      1:       gap = 64'(balance_window);
      2:       gap = 64'(balance_window) + 64'd1;
      default: gap = 64'(balance_window) + 64'd1 + rnd_field(40);
    endcase
    if ($urandom_range(1)) gc = (io + gap > MASK40) ? MASK40 : io + gap;
    else gc = (io >= gap) ? io - gap : 64'd0;

    heap = rnd_field(48);
    case ($urandom_range(2))
      0:       cand = (64'd2 * heap + 64'd4) / 64'd5;
      1:       cand = (heap == 0) ? 64'd0 : (64'd2 * heap + 64'd4) / 64'd5 - 64'd1;
      default: cand = rnd_field(48);
    endcase

    ocap = rnd_field(48);
    case ($urandom_range(2))
      0:       oused = (64'd7 * ocap) / 64'd10;
      1:       oused = (64'd7 * ocap) / 64'd10 + 64'd1;
      default: oused = rnd_field(48);
    endcase
    case ($urandom_range(3))
      0:       omax = ocap;
      1:       omax = (ocap == MASK48) ? ocap : ocap + 64'd1;
      2:       omax = (ocap == 0) ? ocap : ocap - 64'd1;
      default: omax = rnd_field(48);
    endcase

    // smallest footprint that is not slack
    bound = (64'd9 * 64'(dram_budget) + 64'd9) / 64'd10;
    if ($urandom_range(2) == 0) begin
      res = rnd_field(48);
      cache = rnd_field(48);
    end else begin
      mem = (bound != 0 && $urandom_range(1)) ? bound - 64'd1 : bound;
      cache = rnd_field(48) % (mem + 64'd1);
      res = mem - cache;
    end
    return decide_of(gc, io, 1'($urandom), cand, heap, ocap, oused, omax, res, cache);
  endfunction

  // ---------------------------------------------------------------- bus handling
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.op;
    s_tdata <= {5'd0, it.epilog_flags, it.cache_bytes, it.resident_bytes, it.old_max_bytes,
                it.old_used_bytes, it.old_capacity_bytes, it.heap_capacity_bytes,
                it.candidate_bytes, it.device_busy, it.io_time, it.gc_time};
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(advance_policy(it));
    if (it.op == OP_EPILOG) n_epilog++;
    else n_decide++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [3:0] v, logic [47:0] dram, logic [39:0] eps);
    wait_idle();
    cfg_wen <= 1'b1;
    cfg_index <= REG_VARIANT;
    cfg_data <= 48'(v);
    @(posedge clk);
    cfg_index <= REG_DRAM;
    cfg_data <= dram;
    @(posedge clk);
    cfg_index <= REG_EPSILON;
    cfg_data <= 48'(eps);
    @(posedge clk);
    cfg_wen <= 1'b0;
    rule_set = v;
    dram_budget = dram;
    balance_window = eps;
    n_settings++;
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata);
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected: %h", m_tdata);
        failures++;
      end else begin
        want = expected_results.pop_front();
        check_field("next_state", want.next_state, got.next_state);
        check_field("action", want.action, got.action);
        check_field("move_eager", want.move_eager, got.move_eager);
        check_field("eager_written", want.eager_written, got.eager_written);
        check_field("epilog_cleared", want.epilog_cleared, got.epilog_cleared);
        seen_state[want.next_state]++;
        if (want.epilog_cleared) n_cleared++;
      end
    end
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // ---------------------------------------------------------------- tests
  // Register defaults: simple rule set, 100 ms window, no DRAM budget.
  task automatic test_reset_defaults();
    send_item(decide_of(1000, 1000, 1'b0, 0, 0, 0, 0, 0, 0, 0));
    send_item(decide_of(25600 + 77, 77, 1'b0, 0, 10, 0, 0, 0, 0, 0));  // gap equals window
    send_item(decide_of(25601 + 77, 77, 1'b0, 2, 5, 0, 0, 0, 0, 0));   // just outside, move
    send_item(epilog_of(2'b10));                                       // resizing needed
    send_item(decide_of(0, MASK40, 1'b1, 0, 1, 0, 0, 0, 0, 0));        // busy device, io heavy
  endtask

  task automatic test_field_extremes();
    configure(VAR_FULL, MASK48[47:0], 40'd0);
    send_item(decide_of(MASK40, MASK40, 1'b1, MASK48, MASK48, MASK48, MASK48, MASK48, MASK48,
                        MASK48));
    send_item(decide_of(0, 0, 1'b0, 0, 0, 0, 0, 0, 0, 0));
    // zero heap passes the ratio; zero old capacity with used bytes is high
    send_item(decide_of(MASK40, 0, 1'b1, 0, 0, 0, 1, 0, MASK48, 0));
    send_item(epilog_of(2'b11));
  endtask

  // Walks the full rule set through grow, shrink and move waits.
  task automatic test_full_rule_walk();
    send_item(decide_of(1, 0, 1'b0, 0, 1, 0, 1, MASK48, 0, 0));
    send_item(decide_of(5, 0, 1'b0, 0, 1, 0, 1, MASK48, 0, 0));
    send_item(decide_of(0, 9, 1'b1, 0, 1, 0, 1, MASK48, 0, 0));
    send_item(decide_of(7, 7, 1'b0, 0, 1, 0, 0, 0, 0, 0));
    send_item(decide_of(0, 9, 1'b0, 0, 1, 0, 0, 0, 0, 0));            // io heavy with slack
    send_item(decide_of(0, 9, 1'b0, 0, 1, 0, 0, 0, MASK48, MASK48));  // io heavy, no slack
    send_item(decide_of(9, 0, 1'b0, 2, 5, 0, 0, 0, 0, 0));
    send_item(rand_decide());                                          // pending move holds
    send_item(epilog_of(2'b10));
    send_item(epilog_of(2'b01));
  endtask

  // Out-of-range rule set acts as the wait set; widest window balances everything.
  task automatic test_variant_above_eight();
    configure(4'hF, 48'd0, MASK40[39:0]);
    send_item(decide_of(MASK40, 0, 1'b1, MASK48, 1, 0, 0, 1, 0, 0));
    send_item(epilog_of(2'b11));
  endtask

  task automatic test_random_traffic();
    logic [39:0] eps;
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0:       begin tx_idle_pct = 23; rx_idle_pct = 74; end
        1:       begin tx_idle_pct = 74; rx_idle_pct = 23; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      for (int ph = 0; ph < PHASES_PER_REGIME; ph++) begin
        eps = ($urandom_range(3) == 0) ? EPSILON_RESET : 40'(rnd_field(40));
        configure(4'((regime * PHASES_PER_REGIME + ph) % 16), 48'(rnd_field(48)), eps);
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
          // sender holds off until the pipeline has drained
          if (n == ITEMS_PER_PHASE / 2 && ph % 3 == 0) wait_idle();
          if ($urandom_range(99) < 15) send_item(epilog_of(2'($urandom)));
          else send_item(rand_decide());
        end
      end
    end
  endtask

  initial begin
    tx_idle_pct = 23;
    rx_idle_pct = 74;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_field_extremes();
    test_full_rule_walk();
    test_variant_above_eight();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("tb: %0d decide and %0d epilog transactions over %0d register settings",
             n_decide, n_epilog, n_settings);
    $display("tb: %0d moves cleared; results in none/move/grow/shrink: %0d/%0d/%0d/%0d",
             n_cleared, seen_state[0], seen_state[1], seen_state[2], seen_state[3]);
    if (failures == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

@@ heap_resize_policy_fsm.f @@
rtl/hrp_pkg.sv
rtl/hrp_pred.sv
rtl/hrp_rules.sv
rtl/heap_resize_policy_fsm.sv
tb/sv/heap_resize_policy_fsm_tb.sv
